### rtl/core/diff_drive_encoder_odometry_macros.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent assertion forms for the odometry core.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ENCODER_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ENCODER_ODOMETRY_MACROS_SVH

// same-cycle implication, held off during reset
`define DDEO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DDEO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ddeo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Constants, CORDIC arctangent table and fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddeo_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_RAD_PER_TICK = 2'd0;
    localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd1;
    localparam logic [1:0] CFG_WHEEL_BASE   = 2'd2;

    // register reset values
    localparam logic [23:0] RST_RAD_PER_TICK = 24'd146408;
    localparam logic [15:0] RST_WHEEL_RADIUS = 16'd1966;
    localparam logic [17:0] RST_WHEEL_BASE   = 18'd16908;

    // encoder count width
    localparam int ENC_BITS = 16;

    // CORDIC constants, angles in Q16, gain in Q30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;

    // milliseconds per second
    localparam logic signed [33:0] MS_PER_S = 34'sd1000;

    typedef logic signed [33:0] t_mop;
    typedef logic signed [67:0] t_prod;

    // arctangent of 2^-i in Q16
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input t_prod v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // arithmetic right shift, round to nearest, ties upward
    function automatic t_prod shr_rnd(input t_prod v, input int unsigned s);
        t_prod half;
        half = 68'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

endpackage

### rtl/core/diff_drive_encoder_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive wheel odometry
// Wheel angles, wheel rates and integrated pose from encoder samples.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tuser selects an odometry update (0) or a
// clear of wheel angles and rates (1); tdata carries timestamp, both encoder
// counts and the external heading. Each item gives one result item on
// m_axis with pose, pose rates, wheel angles and wheel rates.
// Configuration (tick scale, wheel radius, wheel base) is written on the
// cfg channel, which is always ready; write it only while the core is idle.
// One shared multiplier and one shared radix-2 divider (32 steps per
// quotient) run under a sequencer; a CORDIC for the heading runs alongside.
// An update with a new timestamp and a valid time step runs six divisions;
// without a new timestamp it runs four, with no valid step yet only the
// heading division; a clear skips all arithmetic.
// s_axis_tready is high only while the sequencer is idle. The finished
// result sits in an output register, so the next item is accepted while it
// waits; a stalled receiver holds the core at its final step.
// Reset (synchronous, active low) zeroes the persistent state and restores the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "diff_drive_encoder_odometry_macros.svh"

module diff_drive_encoder_odometry import ddeo_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // timestamp_ms, left_ticks, right_ticks, heading
    input  logic [63:0]  s_axis_tdata,
    // operation
    input  logic         s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pose_x, pose_y, pose_yaw, x_rate, y_rate, turn_rate,
    // left_angle, right_angle, left_rate, right_rate
    output logic [319:0] m_axis_tdata,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_data
);

    // sequencer codes
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MUL_L  = 5'd1;
    localparam logic [4:0] ST_MUL_R  = 5'd2;
    localparam logic [4:0] ST_ANG    = 5'd3;
    localparam logic [4:0] ST_MUL_DS = 5'd4;
    localparam logic [4:0] ST_MUL_DY = 5'd5;
    localparam logic [4:0] ST_YAW_GO = 5'd6;
    localparam logic [4:0] ST_YAW_W  = 5'd7;
    localparam logic [4:0] ST_MUL_DX = 5'd8;
    localparam logic [4:0] ST_MUL_SY = 5'd9;
    localparam logic [4:0] ST_POS    = 5'd10;
    localparam logic [4:0] ST_POS2   = 5'd11;
    localparam logic [4:0] ST_MUL_LR = 5'd12;
    localparam logic [4:0] ST_LR_GO  = 5'd13;
    localparam logic [4:0] ST_LR_W   = 5'd14;
    localparam logic [4:0] ST_MUL_RR = 5'd15;
    localparam logic [4:0] ST_RR_GO  = 5'd16;
    localparam logic [4:0] ST_RR_W   = 5'd17;
    localparam logic [4:0] ST_RCHK   = 5'd18;
    localparam logic [4:0] ST_MUL_XR = 5'd19;
    localparam logic [4:0] ST_XR_GO  = 5'd20;
    localparam logic [4:0] ST_XR_W   = 5'd21;
    localparam logic [4:0] ST_MUL_YR = 5'd22;
    localparam logic [4:0] ST_YR_GO  = 5'd23;
    localparam logic [4:0] ST_YR_W   = 5'd24;
    localparam logic [4:0] ST_MUL_WR = 5'd25;
    localparam logic [4:0] ST_WR_GO  = 5'd26;
    localparam logic [4:0] ST_WR_W   = 5'd27;
    localparam logic [4:0] ST_FIN    = 5'd28;

    logic [4:0] r_state;

    // configuration
    logic [23:0] r_rpt;
    logic [15:0] r_wr;
    logic [17:0] r_wb;

    // current item
    logic        r_op;
    logic [15:0] r_ts, r_lt, r_rt;

    // persistent state
    logic [15:0]        r_prev_l, r_prev_r, r_prev_t;
    logic               r_have_first;
    logic signed [15:0] r_last_step;
    logic signed [31:0] r_lang, r_rang, r_lrate, r_rrate;
    logic signed [31:0] r_px, r_py, r_pyaw;

    // per-item intermediates
    logic signed [32:0] r_dl, r_dr;
    logic signed [31:0] r_ds, r_dyaw, r_dx, r_dy;
    logic signed [31:0] r_xr, r_yr, r_wrate;
    t_prod              r_prod;

    // output register
    logic         r_ovalid;
    logic [319:0] r_out;

    // CORDIC
    logic               r_cd_busy, r_cd_flip;
    logic [3:0]         r_cd_i;
    logic signed [32:0] r_cd_x, r_cd_y;
    logic signed [20:0] r_cd_z;

    // divider
    logic        r_dv_busy, r_dv_neg, r_dv_ovf;
    logic [4:0]  r_dv_cnt;
    logic [17:0] r_dv_ud, r_dv_rem;
    logic [31:0] r_dv_lo, r_dv_q;

    logic accept;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // wrapped tick differences, zero on the first sample
    logic signed [15:0] tdl, tdr;
    assign tdl = r_have_first ? $signed(r_lt - r_prev_l) : 16'sd0;
    assign tdr = r_have_first ? $signed(r_rt - r_prev_r) : 16'sd0;

    logic signed [32:0] cos_q30, sin_q30;
    assign cos_q30 = r_cd_flip ? -r_cd_x : r_cd_x;
    assign sin_q30 = r_cd_flip ? -r_cd_y : r_cd_y;

    // shared multiplier operand select
    t_mop m_a, m_b, rpt_op, wr_op;
    assign rpt_op = $signed({10'd0, r_rpt});
    assign wr_op  = $signed({18'd0, r_wr});

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_MUL_L: begin
                m_a = 34'(tdl);
                m_b = rpt_op;
            end
            ST_MUL_R: begin
                m_a = 34'(tdr);
                m_b = rpt_op;
            end
            ST_MUL_DS: begin
                m_a = 34'(r_dl) + 34'(r_dr);
                m_b = wr_op;
            end
            ST_MUL_DY: begin
                m_a = 34'(r_dr) - 34'(r_dl);
                m_b = wr_op;
            end
            ST_MUL_DX: begin
                m_a = 34'(r_ds);
                m_b = 34'(cos_q30);
            end
            ST_MUL_SY: begin
                m_a = 34'(r_ds);
                m_b = 34'(sin_q30);
            end
            ST_MUL_LR: begin
                m_a = 34'(r_dl);
                m_b = MS_PER_S;
            end
            ST_MUL_RR: begin
                m_a = 34'(r_dr);
                m_b = MS_PER_S;
            end
            ST_MUL_XR: begin
                m_a = 34'(r_dx);
                m_b = MS_PER_S;
            end
            ST_MUL_YR: begin
                m_a = 34'(r_dy);
                m_b = MS_PER_S;
            end
            ST_MUL_WR: begin
                m_a = 34'(r_dyaw);
                m_b = MS_PER_S;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // divider launch: magnitudes, rounding bias and overflow precheck
    logic               dv_go;
    logic [17:0]        wb_nz, dv_ud;
    logic signed [51:0] dv_num;
    logic signed [18:0] dv_den;
    logic [51:0]        dv_un;
    logic [18:0]        dv_den_abs;
    logic [52:0]        dv_nsum;

    assign dv_go = r_state inside {ST_YAW_GO, ST_LR_GO, ST_RR_GO, ST_XR_GO, ST_YR_GO,
                                   ST_WR_GO};
    assign wb_nz      = (r_wb == 18'd0) ? 18'd1 : r_wb;
    assign dv_num     = r_prod[51:0];
    assign dv_den     = (r_state == ST_YAW_GO) ? $signed({1'b0, wb_nz}) : 19'(r_last_step);
    assign dv_un      = dv_num[51] ? 52'(-dv_num) : 52'(dv_num);
    assign dv_den_abs = dv_den[18] ? 19'(-dv_den) : 19'(dv_den);
    assign dv_ud      = dv_den_abs[17:0];
    assign dv_nsum    = {1'b0, dv_un} + 53'(dv_ud >> 1);

    // one quotient bit per step
    logic [18:0] dv_trial;
    logic        dv_fit;
    assign dv_trial = {r_dv_rem, r_dv_lo[31]};
    assign dv_fit   = (dv_trial >= {1'b0, r_dv_ud});

    // rounded, signed, clamped quotient
    logic signed [32:0] dv_sq;
    logic signed [31:0] dv_res;
    assign dv_sq  = r_dv_neg ? -$signed({1'b0, r_dv_q}) : $signed({1'b0, r_dv_q});
    assign dv_res = r_dv_ovf ? (r_dv_neg ? 32'sh80000000 : 32'sh7fffffff)
                             : sat32(68'(dv_sq));

    logic dv_wait_done;
    assign dv_wait_done = !r_dv_busy;

    // heading to CORDIC angle, folded into the half plane
    logic signed [15:0] in_hd;
    logic signed [20:0] hd_z;
    assign in_hd = $signed(s_axis_tdata[63:48]);
    assign hd_z  = 21'(in_hd) <<< 3;

    logic signed [20:0] cd_atan;
    assign cd_atan = $signed({5'd0, atan_q16(r_cd_i)});

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpt <= RST_RAD_PER_TICK;
            r_wr  <= RST_WHEEL_RADIUS;
            r_wb  <= RST_WHEEL_BASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_RAD_PER_TICK: r_rpt <= i_cfg_data;
                CFG_WHEEL_RADIUS: r_wr  <= i_cfg_data[15:0];
                CFG_WHEEL_BASE:   r_wb  <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // CORDIC rotation, one micro-rotation a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_busy <= 1'b0;
            r_cd_i    <= '0;
            r_cd_flip <= 1'b0;
        end else if (accept) begin
            r_cd_busy <= 1'b1;
            r_cd_i    <= '0;
            r_cd_x    <= CORDIC_GAIN;
            r_cd_y    <= '0;
            if (hd_z > HALF_PI_Q16) begin
                r_cd_z    <= hd_z - PI_Q16;
                r_cd_flip <= 1'b1;
            end else if (hd_z < -HALF_PI_Q16) begin
                r_cd_z    <= hd_z + PI_Q16;
                r_cd_flip <= 1'b1;
            end else begin
                r_cd_z    <= hd_z;
                r_cd_flip <= 1'b0;
            end
        end else if (r_cd_busy) begin
            if (r_cd_z >= 0) begin
                r_cd_x <= r_cd_x - (r_cd_y >>> r_cd_i);
                r_cd_y <= r_cd_y + (r_cd_x >>> r_cd_i);
                r_cd_z <= r_cd_z - cd_atan;
            end else begin
                r_cd_x <= r_cd_x + (r_cd_y >>> r_cd_i);
                r_cd_y <= r_cd_y - (r_cd_x >>> r_cd_i);
                r_cd_z <= r_cd_z + cd_atan;
            end
            r_cd_i <= r_cd_i + 4'd1;
            if (r_cd_i == 4'd15)
                r_cd_busy <= 1'b0;
        end
    end

    // shared restoring divider, 32 quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (dv_go) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= '0;
            r_dv_neg  <= dv_num[51] ^ dv_den[18];
            r_dv_ud   <= dv_ud;
            r_dv_ovf  <= (dv_nsum[52:32] >= 21'(dv_ud));
            r_dv_rem  <= dv_nsum[49:32];
            r_dv_lo   <= dv_nsum[31:0];
            r_dv_q    <= '0;
        end else if (r_dv_busy) begin
            r_dv_rem <= dv_fit ? 18'(dv_trial - {1'b0, r_dv_ud}) : dv_trial[17:0];
            r_dv_lo  <= {r_dv_lo[30:0], 1'b0};
            r_dv_q   <= {r_dv_q[30:0], dv_fit};
            r_dv_cnt <= r_dv_cnt + 5'd1;
            if (r_dv_cnt == 5'd31)
                r_dv_busy <= 1'b0;
        end
    end

    // sequencer and odometry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_prev_l     <= '0;
            r_prev_r     <= '0;
            r_prev_t     <= '0;
            r_have_first <= 1'b0;
            r_last_step  <= '0;
            r_lang       <= '0;
            r_rang       <= '0;
            r_lrate      <= '0;
            r_rrate      <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_pyaw       <= '0;
        end else begin
            // drop the result once taken, unless the final step reloads it
            if (r_ovalid && m_axis_tready && r_state != ST_FIN)
                r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_op <= s_axis_tuser;
                        r_ts <= s_axis_tdata[15:0];
                        r_lt <= s_axis_tdata[31:16];
                        r_rt <= s_axis_tdata[47:32];
                        if (s_axis_tuser) begin
                            r_lang  <= '0;
                            r_rang  <= '0;
                            r_lrate <= '0;
                            r_rrate <= '0;
                            r_xr    <= '0;
                            r_yr    <= '0;
                            r_wrate <= '0;
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_MUL_L;
                        end
                    end
                end
                ST_MUL_L: r_state <= ST_MUL_R;
                ST_MUL_R: begin
                    r_dl    <= 33'(shr_rnd(r_prod, 8));
                    r_state <= ST_ANG;
                end
                ST_ANG: begin
                    r_dr    <= 33'(shr_rnd(r_prod, 8));
                    r_state <= ST_MUL_DS;
                end
                ST_MUL_DS: begin
                    // accumulate wheel angles, advance counts
                    r_lang   <= sat32(68'(r_lang) + 68'(r_dl));
                    r_rang   <= sat32(68'(r_rang) + 68'(r_dr));
                    r_prev_l <= r_lt;
                    r_prev_r <= r_rt;
                    if (!r_have_first) begin
                        r_prev_t     <= r_ts;
                        r_have_first <= 1'b1;
                    end
                    r_state <= ST_MUL_DY;
                end
                ST_MUL_DY: begin
                    r_ds    <= sat32(shr_rnd(r_prod, 17));
                    r_state <= ST_YAW_GO;
                end
                ST_YAW_GO: r_state <= ST_YAW_W;
                ST_YAW_W: begin
                    if (dv_wait_done && !r_cd_busy) begin
                        r_dyaw  <= dv_res;
                        r_state <= ST_MUL_DX;
                    end
                end
                ST_MUL_DX: r_state <= ST_MUL_SY;
                ST_MUL_SY: begin
                    r_dx    <= sat32(shr_rnd(r_prod, 30));
                    r_state <= ST_POS;
                end
                ST_POS: begin
                    r_dy    <= sat32(shr_rnd(r_prod, 30));
                    r_px    <= sat32(68'(r_px) + 68'(r_dx));
                    r_pyaw  <= sat32(68'(r_pyaw) + 68'(r_dyaw));
                    r_state <= ST_POS2;
                end
                ST_POS2: begin
                    r_py <= sat32(68'(r_py) + 68'(r_dy));
                    // new timestamp: take the wrapped step, refresh wheel rates
                    if (r_ts != r_prev_t) begin
                        r_last_step <= $signed(r_ts - r_prev_t);
                        r_prev_t    <= r_ts;
                        r_state     <= ST_MUL_LR;
                    end else begin
                        r_state <= ST_RCHK;
                    end
                end
                ST_MUL_LR: r_state <= ST_LR_GO;
                ST_LR_GO:  r_state <= ST_LR_W;
                ST_LR_W: begin
                    if (dv_wait_done) begin
                        r_lrate <= dv_res;
                        r_state <= ST_MUL_RR;
                    end
                end
                ST_MUL_RR: r_state <= ST_RR_GO;
                ST_RR_GO:  r_state <= ST_RR_W;
                ST_RR_W: begin
                    if (dv_wait_done) begin
                        r_rrate <= dv_res;
                        r_state <= ST_RCHK;
                    end
                end
                ST_RCHK: begin
                    if (r_last_step == 16'sd0) begin
                        r_xr    <= '0;
                        r_yr    <= '0;
                        r_wrate <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_MUL_XR;
                    end
                end
                ST_MUL_XR: r_state <= ST_XR_GO;
                ST_XR_GO:  r_state <= ST_XR_W;
                ST_XR_W: begin
                    if (dv_wait_done) begin
                        r_xr    <= dv_res;
                        r_state <= ST_MUL_YR;
                    end
                end
                ST_MUL_YR: r_state <= ST_YR_GO;
                ST_YR_GO:  r_state <= ST_YR_W;
                ST_YR_W: begin
                    if (dv_wait_done) begin
                        r_yr    <= dv_res;
                        r_state <= ST_MUL_WR;
                    end
                end
                ST_MUL_WR: r_state <= ST_WR_GO;
                ST_WR_GO:  r_state <= ST_WR_W;
                ST_WR_W: begin
                    if (dv_wait_done) begin
                        r_wrate <= dv_res;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_out    <= {r_rrate, r_lrate, r_rang, r_lang, r_wrate, r_yr, r_xr,
                                     r_pyaw, r_py, r_px};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a clear item skips all arithmetic
    logic op_clear_fin;
    assign op_clear_fin = (r_state == ST_FIN) && r_op;

    `DDEO_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != ST_IDLE,
        "accepted item did not start the sequencer")
    `DDEO_ASSERT_IMP(a_div_free_at_launch, i_clk, i_rst_n, dv_go, !r_dv_busy,
        "divider launched while busy")
    `DDEO_ASSERT_IMP(a_cordic_done_for_mul, i_clk, i_rst_n,
        r_state == ST_MUL_DX || r_state == ST_MUL_SY, !r_cd_busy,
        "heading rotation used before it finished")
    `DDEO_ASSERT_IMP(a_clear_zero_rates, i_clk, i_rst_n, op_clear_fin,
        r_lrate == 32'sd0 && r_rrate == 32'sd0 && r_xr == 32'sd0,
        "clear item left nonzero rates")

endmodule
